@@ rtl/lrupr_pkg.sv @@
`timescale 1ns / 1ps
// Package for the LRU page replacement block: sizes, constants and the
// structures passed along and into the row of frame cells. No dependencies.
package lrupr_pkg;

    localparam int FRAME_SLOTS = 8;
    localparam int PAGE_BITS   = 16;
    localparam int SLOT_BITS   = $clog2(FRAME_SLOTS);
    localparam int RANK_BITS   = SLOT_BITS;
    localparam int AGE_BITS    = RANK_BITS + 1;
    localparam int COUNT_BITS  = $clog2(FRAME_SLOTS + 1);
    localparam int CFG_BITS    = 4;
    localparam int FAULT_BITS  = 32;
    localparam int LIM_BITS    = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

    localparam logic [CFG_BITS-1:0]   FRAMES_RESET = CFG_BITS'(8);
    localparam logic [AGE_BITS-1:0]   AGE_ALL      = AGE_BITS'(FRAME_SLOTS);
    localparam logic [FAULT_BITS-1:0] FAULT_MAX    = '1;

    typedef struct packed {
        logic                 valid;
        logic [PAGE_BITS-1:0] page;
        logic                 found;
        logic [SLOT_BITS-1:0] slot;
        logic [RANK_BITS-1:0] hit_rank;
        logic                 have;
        logic [SLOT_BITS-1:0] best_slot;
        logic [RANK_BITS-1:0] best_rank;
        logic [PAGE_BITS-1:0] best_page;
    } t_probe;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] slot;
        logic [AGE_BITS-1:0]  old_rank;
        logic                 write_page;
        logic [PAGE_BITS-1:0] page;
    } t_update;

endpackage

@@ rtl/lrupr_cell.sv @@
`timescale 1ns / 1ps
// One frame cell: holds a page, its valid mark and its recency rank, and
// passes the search probe on to the next cell. Depends on lrupr_pkg.
module lrupr_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lrupr_pkg::SLOT_BITS-1:0]   i_index,
    input  logic [lrupr_pkg::COUNT_BITS-1:0]  i_limit,
    input  lrupr_pkg::t_probe                 i_probe,
    output lrupr_pkg::t_probe                 o_probe,
    input  lrupr_pkg::t_update                i_update
);
    import lrupr_pkg::*;

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [RANK_BITS-1:0] r_rank;
    t_probe               r_probe;
    t_probe               n_probe;

    logic w_active;
    logic w_match;
    logic w_older;
    logic w_target;
    logic w_age;

    always_comb begin
        w_active = r_valid && (COUNT_BITS'(i_index) < i_limit);
        w_match  = w_active && (r_page == i_probe.page);
        w_older  = w_active && (!i_probe.have || (r_rank > i_probe.best_rank));
        n_probe  = i_probe;
        if (w_match && !i_probe.found) begin
            n_probe.found    = 1'b1;
            n_probe.slot     = i_index;
            n_probe.hit_rank = r_rank;
        end
        if (w_older) begin
            n_probe.have      = 1'b1;
            n_probe.best_slot = i_index;
            n_probe.best_rank = r_rank;
            n_probe.best_page = r_page;
        end
        w_target = i_update.en && (i_update.slot == i_index);
        w_age    = i_update.en && r_valid && ({1'b0, r_rank} < i_update.old_rank);
    end

    always_ff @(posedge i_clk) begin
        if (w_target && i_update.write_page) begin
            r_page <= i_update.page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
            if (w_target) begin
                r_valid <= 1'b1;
                r_rank  <= '0;
            end else if (w_age) begin
                r_rank <= r_rank + RANK_BITS'(1);
            end
        end
    end

    assign o_probe = r_probe;

endmodule

@@ rtl/lru_page_replacement.sv @@
`timescale 1ns / 1ps
// Top level of the LRU page replacement block: the row of frame cells and
// the controller that commits each decision. Depends on lrupr_pkg, lrupr_cell.
//
// Usage: a page reference is transferred on the input channel when
// i_in_valid and o_in_ready are both high. One result per reference is
// transferred on the output channel when o_out_valid and i_out_ready are
// both high; it carries the hit flag, the frame slot, any evicted page and
// the saturating fault count.
// A reference travels along the row of frame cells, one cell per cycle,
// through each cell's probe register into the finished-search register,
// from which the result is loaded into the output register. One reference
// is in the block at a time; the next one is taken the cycle after the
// result is loaded. If the receiver stalls, the result is held in the
// output register and the finished search waits, so no further reference
// is taken until the output register is free again.
// The frame count register is written through i_cfg_we and i_cfg_wdata and
// must only be changed while the block is idle.
// Synchronous reset empties every frame, clears the fault count and sets
// the frame count to eight.
module lru_page_replacement (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [lrupr_pkg::PAGE_BITS-1:0]   i_page_number,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic [lrupr_pkg::SLOT_BITS-1:0]   o_frame_slot,
    output logic                              o_evicted_valid,
    output logic [lrupr_pkg::PAGE_BITS-1:0]   o_evicted_page,
    output logic [lrupr_pkg::FAULT_BITS-1:0]  o_fault_total,
    input  logic                              i_cfg_we,
    input  logic [lrupr_pkg::CFG_BITS-1:0]    i_cfg_wdata
);
    import lrupr_pkg::*;

    logic [CFG_BITS-1:0]   r_frames;
    logic                  r_busy;
    logic [COUNT_BITS-1:0] r_filled;
    logic [FAULT_BITS-1:0] r_fault;
    t_probe                r_fin;
    logic                  r_out_valid;
    logic                  r_hit;
    logic [SLOT_BITS-1:0]  r_slot;
    logic                  r_ev_valid;
    logic [PAGE_BITS-1:0]  r_ev_page;

    t_probe                n_fin;
    logic [COUNT_BITS-1:0] n_filled;
    logic [FAULT_BITS-1:0] n_fault;
    logic                  n_ev_valid;
    logic [PAGE_BITS-1:0]  n_ev_page;

    t_probe                w_chain [FRAME_SLOTS+1];
    logic [FRAME_SLOTS-1:0] w_tok_valid;
    t_update               w_update;
    logic [LIM_BITS-1:0]   w_cfg_ext;
    logic [COUNT_BITS-1:0] w_limit;
    logic                  w_accept;
    logic                  w_commit;

    assign w_accept   = i_in_valid && !r_busy;
    assign w_commit   = r_fin.valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_busy;

    always_comb begin
        w_cfg_ext = LIM_BITS'(r_frames);
        if (w_cfg_ext == '0) begin
            w_limit = COUNT_BITS'(1);
        end else if (w_cfg_ext > LIM_BITS'(FRAME_SLOTS)) begin
            w_limit = COUNT_BITS'(FRAME_SLOTS);
        end else begin
            w_limit = COUNT_BITS'(w_cfg_ext);
        end
    end

    always_comb begin
        w_chain[0]       = '0;
        w_chain[0].valid = w_accept;
        w_chain[0].page  = i_page_number;
    end

    for (genvar g = 0; g < FRAME_SLOTS; g++) begin : g_cell
        lrupr_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (SLOT_BITS'(g)),
            .i_limit  (w_limit),
            .i_probe  (w_chain[g]),
            .o_probe  (w_chain[g+1]),
            .i_update (w_update)
        );
        assign w_tok_valid[g] = w_chain[g+1].valid;
    end

    always_comb begin
        n_fin = r_fin;
        if (w_chain[FRAME_SLOTS].valid) begin
            n_fin = w_chain[FRAME_SLOTS];
        end else if (w_commit) begin
            n_fin.valid = 1'b0;
        end

        w_update            = '0;
        w_update.en         = w_commit;
        w_update.page       = r_fin.page;
        n_filled            = r_filled;
        n_ev_valid          = 1'b0;
        n_ev_page           = '0;
        if (r_fin.found) begin
            w_update.slot     = r_fin.slot;
            w_update.old_rank = {1'b0, r_fin.hit_rank};
        end else if (r_filled < w_limit) begin
            w_update.slot       = r_filled[SLOT_BITS-1:0];
            w_update.old_rank   = AGE_ALL;
            w_update.write_page = 1'b1;
            n_filled            = r_filled + COUNT_BITS'(1);
        end else begin
            w_update.slot       = r_fin.best_slot;
            w_update.old_rank   = {1'b0, r_fin.best_rank};
            w_update.write_page = 1'b1;
            n_ev_valid          = 1'b1;
            n_ev_page           = r_fin.best_page;
        end

        n_fault = r_fault;
        if (!r_fin.found && (r_fault != FAULT_MAX)) begin
            n_fault = r_fault + FAULT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_hit      <= r_fin.found;
            r_slot     <= w_update.slot;
            r_ev_valid <= n_ev_valid;
            r_ev_page  <= n_ev_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames    <= FRAMES_RESET;
            r_busy      <= 1'b0;
            r_filled    <= '0;
            r_fault     <= '0;
            r_fin       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frames <= i_cfg_wdata;
            end
            r_fin <= n_fin;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end
            if (w_commit) begin
                r_filled    <= n_filled;
                r_fault     <= n_fault;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_frame_slot    = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_total   = r_fault;

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_tok_valid, r_fin.valid}))
        else $error("More than one reference in the cell row.");

    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((|w_tok_valid) || r_fin.valid) |-> !o_in_ready)
        else $error("Input ready while a reference is being searched.");

    a_evict_is_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evicted_valid) |-> (!o_hit && (r_filled != '0)))
        else $error("Eviction reported on a hit or with no frame filled.");

    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= COUNT_BITS'(FRAME_SLOTS))
        else $error("Fill count beyond the number of frames.");
`endif

endmodule
